@@ design/h2d_pkg.sv @@
// Shared constants, types and state codes for the 2-D heat stencil step.
package h2d_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 1024;
	localparam int LINE_DEPTH = MAX_COLS + 2;
	localparam int COL_W      = $clog2(LINE_DEPTH);
	localparam int ROW_W      = $clog2(MAX_ROWS + 2);

	localparam int SIZE_W     = 11;
	localparam int DATA_W     = 32;
	localparam int RES_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_SHIFT = 30;
	localparam int MUL_W      = DATA_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int SHR_W      = ACC_W - FRAC_SHIFT;
	localparam int OUT_W      = DATA_W + RES_W;

	localparam logic [SIZE_W-1:0]        GRID_COLS_RST     = SIZE_W'(16);
	localparam logic [SIZE_W-1:0]        GRID_ROWS_RST     = SIZE_W'(16);
	localparam logic signed [DATA_W-1:0] CENTER_WEIGHT_RST = 32'sh4000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLS,
		REG_GRID_ROWS,
		REG_WEIGHT_X,
		REG_WEIGHT_Y,
		REG_CENTER_WEIGHT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_MUL,
		ST_DRAIN,
		ST_ROUND,
		ST_DIFF,
		ST_SQUARE,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		TERM_N,
		TERM_S,
		TERM_W,
		TERM_E,
		TERM_C
	} term_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
	} mac_ctl_t;

endpackage

@@ design/h2d_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module h2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/h2d_mac.sv @@
// Shared signed multiplier with registered product and wide accumulator.
module h2d_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  h2d_pkg::mac_ctl_t                   ctl,
	input  logic signed [h2d_pkg::MUL_W-1:0]    op_a,
	input  logic signed [h2d_pkg::MUL_W-1:0]    op_b,
	output logic signed [h2d_pkg::PROD_W-1:0]   prod,
	output logic signed [h2d_pkg::ACC_W-1:0]    acc
);
	import h2d_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     acc_en_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= ctl.mul_en & ctl.acc_en;
		end
	end

	// product registered from the operands, added into the sum in the cycle after
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= op_a * op_b;
		end
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign prod = prod_s1;
	assign acc  = acc_q;

endmodule

@@ design/heat2d_explicit_stencil_step.sv @@
// Top level: explicit five-point heat stencil with line buffers and residual sum.
// Each sample is taken in idle, then runs read, fetch, done; an interior point
// adds a multiply per stencil term, drain, round, diff and square, set by the
// one shared 33x33 multiplier (five stencil terms and the squared change) and
// by the single read port of the middle line buffer (centre, then east).
// A result shows on m_axis_tvalid the cycle after its last step; a full output
// register lets the next sample enter while that result waits.
// Reset clears counters, residual sum and registers to defaults; line buffers
// are not cleared and hold nothing valid until the first row pass writes them.
module heat2d_explicit_stencil_step (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [h2d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [h2d_pkg::DATA_W-1:0]          cfg_wdata,
	// sample stream in
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [h2d_pkg::DATA_W-1:0]          s_axis_tdata,   // [31:0] sample
	// result stream out
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [h2d_pkg::OUT_W-1:0]           m_axis_tdata,   // [31:0] new_value, [95:32] residual
	output logic                                m_axis_tuser,   // [0] is_residual
	output logic                                m_axis_tlast
);
	import h2d_pkg::*;

	// configuration registers
	logic [SIZE_W-1:0]        grid_cols_q;
	logic [SIZE_W-1:0]        grid_rows_q;
	logic signed [DATA_W-1:0] weight_x_q;
	logic signed [DATA_W-1:0] weight_y_q;
	logic signed [DATA_W-1:0] center_weight_q;

	// control state
	state_t            state_q, state_d;
	term_t             term_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              interior_q;
	logic              out_vld_q;

	// payload registers
	logic [RES_W-1:0]         res_sum_q;
	logic signed [DATA_W-1:0] sample_q;
	logic signed [DATA_W-1:0] west_q;
	logic signed [DATA_W-1:0] ctr_q;
	logic signed [DATA_W-1:0] north_q;
	logic signed [DATA_W-1:0] east_q;
	logic signed [DATA_W-1:0] nv_q;
	logic [DATA_W-1:0]        out_value_q;
	logic [RES_W-1:0]         out_res_q;
	logic                     out_user_q;
	logic                     out_last_q;

	// line buffer ports
	logic              mid_re, mid_we, nor_re, nor_we;
	logic [COL_W-1:0]  mid_raddr;
	logic [DATA_W-1:0] mid_rdata, nor_rdata;

	// multiplier
	mac_ctl_t                 mac_ctl;
	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] mac_prod;
	logic signed [ACC_W-1:0]  mac_acc;

	// derived control
	logic [COL_W-1:0]  cols_eff;
	logic [ROW_W-1:0]  rows_eff;
	logic              interior, col_end, row_end, pass_end, emit, done_go, out_load;
	logic signed [ACC_W-1:0]  rnd;
	logic [SHR_W-1:0]         shr;
	logic signed [DATA_W-1:0] nv;
	logic signed [MUL_W-1:0]  diff, abs_diff;
	logic [RES_W:0]           res_sum;

	h2d_ram #(.WIDTH(DATA_W), .DEPTH(LINE_DEPTH)) u_north_line (
		.clk   (clk),
		.we    (nor_we),
		.waddr (col_q),
		.wdata (mid_rdata),
		.re    (nor_re),
		.raddr (col_q),
		.rdata (nor_rdata)
	);

	h2d_ram #(.WIDTH(DATA_W), .DEPTH(LINE_DEPTH)) u_middle_line (
		.clk   (clk),
		.we    (mid_we),
		.waddr (col_q),
		.wdata (sample_q),
		.re    (mid_re),
		.raddr (mid_raddr),
		.rdata (mid_rdata)
	);

	h2d_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod   (mac_prod),
		.acc    (mac_acc)
	);

	// clamp sizes to 1..MAX
	always_comb begin
		if (grid_cols_q == '0) begin
			cols_eff = COL_W'(1);
		end else if (grid_cols_q > MAX_COLS) begin
			cols_eff = COL_W'(MAX_COLS);
		end else begin
			cols_eff = COL_W'(grid_cols_q);
		end
		if (grid_rows_q == '0) begin
			rows_eff = ROW_W'(1);
		end else if (grid_rows_q > MAX_ROWS) begin
			rows_eff = ROW_W'(MAX_ROWS);
		end else begin
			rows_eff = ROW_W'(grid_rows_q);
		end
	end

	// the south neighbor of an interior point arrives one row below it
	assign interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(1)) && (col_q <= cols_eff);
	assign col_end  = {1'b0, col_q} >= ((COL_W+1)'(cols_eff) + (COL_W+1)'(1));
	assign row_end  = {1'b0, row_q} >= ((ROW_W+1)'(rows_eff) + (ROW_W+1)'(1));
	assign pass_end = col_end && row_end;
	assign emit     = interior_q || pass_end;

	// round half up to Q16.16, then saturate to 32 bits
	always_comb begin
		rnd = mac_acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
		shr = rnd[ACC_W-1:FRAC_SHIFT];
		if (!shr[SHR_W-1] && (|shr[SHR_W-2:DATA_W-1])) begin
			nv = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (shr[SHR_W-1] && !(&shr[SHR_W-2:DATA_W-1])) begin
			nv = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			nv = shr[DATA_W-1:0];
		end
	end

	assign diff     = MUL_W'(ctr_q) - MUL_W'(nv_q);
	assign abs_diff = diff[MUL_W-1] ? -diff : diff;
	assign res_sum  = {1'b0, res_sum_q} + {1'b0, mac_prod[RES_W-1:0]};

	// next state, memory strobes and multiplier operands
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mid_re        = 1'b0;
		mid_we        = 1'b0;
		nor_re        = 1'b0;
		nor_we        = 1'b0;
		mid_raddr     = col_q;
		mac_ctl       = '0;
		op_a          = '0;
		op_b          = '0;
		done_go       = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// read centre and north of this column
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					mid_re  = 1'b1;
					nor_re  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// shift centre down into the north line, fetch east
				nor_we    = 1'b1;
				mid_re    = col_q < COL_W'(LINE_DEPTH - 1);
				mid_raddr = col_q + COL_W'(1);
				state_d   = ST_FETCH;
			end
			ST_FETCH: begin
				mid_we        = 1'b1;
				mac_ctl.clear = 1'b1;
				state_d       = interior ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				mac_ctl.mul_en = 1'b1;
				mac_ctl.acc_en = 1'b1;
				case (term_q)
					TERM_N: begin
						op_a = MUL_W'(weight_y_q);
						op_b = MUL_W'(north_q);
					end
					TERM_S: begin
						op_a = MUL_W'(weight_y_q);
						op_b = MUL_W'(sample_q);
					end
					TERM_W: begin
						op_a = MUL_W'(weight_x_q);
						op_b = MUL_W'(west_q);
					end
					TERM_E: begin
						op_a = MUL_W'(weight_x_q);
						op_b = MUL_W'(east_q);
					end
					TERM_C: begin
						op_a = MUL_W'(center_weight_q);
						op_b = MUL_W'(ctr_q);
					end
					default: begin
						op_a = '0;
						op_b = '0;
					end
				endcase
				if (term_q == TERM_C) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				// square the change on the shared multiplier
				mac_ctl.mul_en = 1'b1;
				op_a           = abs_diff;
				op_b           = abs_diff;
				state_d        = ST_SQUARE;
			end
			ST_SQUARE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free, if this sample emits a result
				if (!emit || !out_vld_q || m_axis_tready) begin
					done_go  = 1'b1;
					out_load = emit;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q     <= GRID_COLS_RST;
			grid_rows_q     <= GRID_ROWS_RST;
			weight_x_q      <= '0;
			weight_y_q      <= '0;
			center_weight_q <= CENTER_WEIGHT_RST;
			state_q         <= ST_IDLE;
			term_q          <= TERM_N;
			col_q           <= '0;
			row_q           <= '0;
			interior_q      <= 1'b0;
			out_vld_q       <= 1'b0;
			res_sum_q       <= '0;
			west_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_GRID_COLS:     grid_cols_q     <= cfg_wdata[SIZE_W-1:0];
					REG_GRID_ROWS:     grid_rows_q     <= cfg_wdata[SIZE_W-1:0];
					REG_WEIGHT_X:      weight_x_q      <= cfg_wdata;
					REG_WEIGHT_Y:      weight_y_q      <= cfg_wdata;
					REG_CENTER_WEIGHT: center_weight_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_FETCH) begin
				interior_q <= interior;
				term_q     <= TERM_N;
			end else if (state_q == ST_MUL && term_q != TERM_C) begin
				term_q <= term_t'(term_q + 3'd1);
			end
			if (state_q == ST_SQUARE) begin
				// saturate the residual at all ones
				res_sum_q <= res_sum[RES_W] ? '1 : res_sum[RES_W-1:0];
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (done_go) begin
				west_q <= ctr_q;
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q     <= '0;
						res_sum_q <= '0;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_q <= s_axis_tdata;
		end
		if (state_q == ST_READ) begin
			ctr_q   <= mid_rdata;
			north_q <= nor_rdata;
		end
		if (state_q == ST_FETCH) begin
			east_q <= mid_rdata;
		end
		if (state_q == ST_ROUND) begin
			nv_q <= nv;
		end
		if (out_load) begin
			if (interior_q) begin
				out_value_q <= nv_q;
				out_res_q   <= '0;
				out_user_q  <= 1'b0;
				out_last_q  <= 1'b0;
			end else begin
				out_value_q <= '0;
				out_res_q   <= res_sum_q;
				out_user_q  <= 1'b1;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_res_q, out_value_q};
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ tb/sv/heat2d_stencil_checker.sv @@
// Stencil result checker: predicts each new grid value and pass residual, compares them.
module heat2d_stencil_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [h2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [h2d_pkg::DATA_W-1:0]    cfg_wdata,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [h2d_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] sample
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [h2d_pkg::OUT_W-1:0]     m_axis_tdata,   // [31:0] new_value, [95:32] residual
	input  logic                          m_axis_tuser,   // [0] is_residual
	input  logic                          m_axis_tlast,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import h2d_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] new_value;
		logic              is_residual;
		logic [RES_W-1:0]  residual;
		logic              last;
	} grid_result_t;

	grid_result_t      stencil_results_q[$];

	logic [SIZE_W-1:0] cfg_cols, cfg_rows;
	logic [DATA_W-1:0] cfg_wx, cfg_wy, cfg_wc;
	logic [DATA_W-1:0] row_above [LINE_DEPTH];
	logic [DATA_W-1:0] row_mid   [LINE_DEPTH];
	logic [DATA_W-1:0] mid_west;
	logic [RES_W-1:0]  sq_change_sum;
	int                col_pos, row_pos;

	function automatic int clamp_dim(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic advance_grid(input logic [DATA_W-1:0] smp);
		int                ncols, nrows;
		logic [DATA_W-1:0] old_mid;
		logic signed [67:0] nrt, sth, wst, est, ctr, kx, ky, kc, acc, upd, delta, mag;
		logic [RES_W-1:0]  sq;
		logic [RES_W:0]    tot;
		grid_result_t      res;
		bit                made;

		ncols   = clamp_dim(int'(cfg_cols), MAX_COLS);
		nrows   = clamp_dim(int'(cfg_rows), MAX_ROWS);
		old_mid = row_mid[col_pos];
		made    = 1'b0;

		if (row_pos >= 2 && col_pos >= 1 && col_pos <= ncols) begin
			nrt = $signed(row_above[col_pos]);
			sth = $signed(smp);
			wst = $signed(mid_west);
			est = $signed(row_mid[col_pos + 1]);
			ctr = $signed(old_mid);
			kx  = $signed(cfg_wx);
			ky  = $signed(cfg_wy);
			kc  = $signed(cfg_wc);
			// exact Q18.46 sum, round half up to Q16.16, then clamp to 32 bits
			acc = ky * (nrt + sth) + kx * (wst + est) + kc * ctr;
			upd = (acc + 68'sd536870912) >>> 30;
			if (upd > 68'sd2147483647)
				upd = 68'sd2147483647;
			else if (upd < -68'sd2147483648)
				upd = -68'sd2147483648;
			delta = ctr - upd;
			mag   = (delta < 0) ? -delta : delta;
			sq    = 64'(mag * mag);
			tot   = {1'b0, sq_change_sum} + {1'b0, sq};
			sq_change_sum = tot[RES_W] ? '1 : tot[RES_W-1:0];

			res.new_value   = upd[DATA_W-1:0];
			res.is_residual = 1'b0;
			res.residual    = '0;
			res.last        = 1'b0;
			stencil_results_q.push_back(res);
			made = 1'b1;
		end

		row_above[col_pos] = old_mid;
		row_mid[col_pos]   = smp;
		mid_west           = old_mid;

		if (col_pos >= ncols + 1) begin
			if (row_pos >= nrows + 1) begin
				if (!made) begin
					res.new_value   = '0;
					res.is_residual = 1'b1;
					res.residual    = sq_change_sum;
					res.last        = 1'b1;
					stencil_results_q.push_back(res);
				end
				row_pos       = 0;
				col_pos       = 0;
				sq_change_sum = '0;
			end else begin
				col_pos = 0;
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endtask

	task automatic check_result();
		grid_result_t want;

		if (stencil_results_q.size() == 0) begin
			$error("result with none expected: new_value %0h, residual %0h, is_residual %0b",
				m_axis_tdata[31:0], m_axis_tdata[95:32], m_axis_tuser);
			fail_count++;
		end else begin
			want = stencil_results_q.pop_front();
			check_field("new_value", 64'(want.new_value), 64'(m_axis_tdata[31:0]));
			check_field("residual", want.residual, m_axis_tdata[95:32]);
			check_field("is_residual", 64'(want.is_residual), 64'(m_axis_tuser));
			check_field("last", 64'(want.last), 64'(m_axis_tlast));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cols      = GRID_COLS_RST;
			cfg_rows      = GRID_ROWS_RST;
			cfg_wx        = '0;
			cfg_wy        = '0;
			cfg_wc        = CENTER_WEIGHT_RST;
			mid_west      = '0;
			sq_change_sum = '0;
			col_pos       = 0;
			row_pos       = 0;
			fail_count    = 0;
			stencil_results_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GRID_COLS:     cfg_cols = cfg_wdata[SIZE_W-1:0];
					REG_GRID_ROWS:     cfg_rows = cfg_wdata[SIZE_W-1:0];
					REG_WEIGHT_X:      cfg_wx   = cfg_wdata;
					REG_WEIGHT_Y:      cfg_wy   = cfg_wdata;
					REG_CENTER_WEIGHT: cfg_wc   = cfg_wdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				advance_grid(s_axis_tdata);
		end
		pending = stencil_results_q.size();
	end

endmodule

@@ tb/sv/tb_heat2d_explicit_stencil_step.sv @@
// Stimulus top for the 2-D heat stencil step: grid passes, handshake pressure and verdict.
module tb_heat2d_explicit_stencil_step;
	timeunit 1ns;
	timeprecision 1ps;
	import h2d_pkg::*;

	// small random grids per idling phase, counted in samples
	localparam int SMALL_SAMPLES  = 300;
	// quiet cycles after the last result before the block counts as idle
	localparam int DRAIN_CYCLES   = 40;
	// long receiver hold-off that fills the block and stalls its input
	localparam int LONG_HOLD      = 600;
	// cycles with no accepted transfer and no register write before the run is declared hung
	localparam int WATCHDOG_LIMIT = 5000;

	typedef enum {PAT_IDENT, PAT_SAT, PAT_TIE, PAT_WIDE, PAT_NARROW, PAT_CORNER} sample_pat_t;
	typedef enum {WT_DIFFUSE, WT_WIDE, WT_CORNER} weight_pat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata;   // [31:0] sample
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // [31:0] new_value, [95:32] residual
	logic                 m_axis_tuser;   // [0] is_residual
	logic                 m_axis_tlast;

	int                   fail_count;
	int                   pending;
	int unsigned          src_idle_pct;
	int unsigned          sink_idle_pct;
	int unsigned          samples_sent;
	bit                   hold_req, hold_ack;

	heat2d_explicit_stencil_step DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	heat2d_stencil_checker STENCIL_CHK (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: drop tready at random, or for one long stretch when asked.
	initial begin
		m_axis_tready = 1'b0;
		hold_ack      = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog: any accepted transfer on either stream or a register write resets the count.
	initial begin
		int quiet_cycles;

		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [DATA_W-1:0] corner_value();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h0000_0001;
			4: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Sample at row r, column c of the padded grid for a given pattern.
	function automatic logic [DATA_W-1:0] pick_sample(sample_pat_t pat, int r, int c);
		case (pat)
			// default weights pass the centre through untouched
			PAT_IDENT:  return (r == 1 && c == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			// most negative centres against full-scale neighbours: clamp and saturate the sum
			PAT_SAT:    return (r == 1 && (c == 1 || c == 2)) ? 32'h8000_0000 : 32'h7fff_ffff;
			// -3 LSB times one half lands exactly on a tie
			PAT_TIE:    return (r == 1 && c == 1) ? 32'hffff_fffd : $urandom;
			PAT_WIDE:   return $urandom;
			PAT_NARROW: return 32'(int'($urandom_range(2097152)) - 1048576);
			default:    return corner_value();
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] corner_weight();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'h4000_0000;
			4: return 32'h2000_0000;
			default: return 32'hc000_0000;
		endcase
	endfunction

	// Write one register; call and return at a falling edge.
	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_weights(input weight_pat_t wp);
		logic [DATA_W-1:0] wx, wy, wc;

		case (wp)
			WT_DIFFUSE: begin
				// stable explicit step: centre weight is one minus the neighbour weights
				wx = $urandom_range(268435456);
				wy = $urandom_range(268435456);
				wc = 32'h4000_0000 - 2 * wx - 2 * wy;
			end
			WT_WIDE: begin
				wx = $urandom;
				wy = $urandom;
				wc = $urandom;
			end
			default: begin
				wx = corner_weight();
				wy = corner_weight();
				wc = corner_weight();
			end
		endcase
		write_reg(REG_WEIGHT_X, wx);
		write_reg(REG_WEIGHT_Y, wy);
		write_reg(REG_CENTER_WEIGHT, wc);
	endtask

	// Offer one sample, idling first at random; return at the falling edge after it is accepted.
	task automatic send_sample(input logic [DATA_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do
			@(posedge clk);
		while (!s_axis_tready);
		samples_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every expected result is back and the block has gone quiet.
	task automatic wait_idle();
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Stream one whole padded grid in raster order, then drain.
	task automatic run_grid(input int cols_cfg, input int rows_cfg, input sample_pat_t pat);
		int nc, nr;

		nc = (cols_cfg < 1) ? 1 : (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
		nr = (rows_cfg < 1) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
		for (int r = 0; r < nr + 2; r++)
			for (int c = 0; c < nc + 2; c++)
				send_sample(pick_sample(pat, r, c));
		s_axis_tvalid <= 1'b0;
		wait_idle();
	endtask

	// Small random grids (a size of zero counts as one) with random weights.
	task automatic run_random_phase(input int unsigned budget);
		int unsigned first;
		int          cols, rows;

		first = samples_sent;
		while (samples_sent - first < budget) begin
			cols = $urandom_range(12, 0);
			rows = $urandom_range(8, 0);
			write_reg(REG_GRID_COLS, cols);
			write_reg(REG_GRID_ROWS, rows);
			write_weights(weight_pat_t'($urandom_range(2)));
			run_grid(cols, rows, sample_pat_t'($urandom_range(5, 3)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_GRID_COLS;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_idle_pct  = 18;
		sink_idle_pct = 46;
		hold_req      = 1'b0;
		samples_sent  = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset weights on a 1x1 grid, so the centre passes through.
		write_reg(REG_GRID_COLS, 1);
		write_reg(REG_GRID_ROWS, 1);
		run_grid(1, 1, PAT_IDENT);

		// Directed: full-scale weights drive the new value and the residual into saturation.
		write_reg(REG_GRID_COLS, 2);
		write_reg(REG_WEIGHT_X, 32'h7fff_ffff);
		write_reg(REG_WEIGHT_Y, 32'h7fff_ffff);
		write_reg(REG_CENTER_WEIGHT, 32'h8000_0000);
		run_grid(2, 1, PAT_SAT);

		// Directed: centre weight of one half on an odd negative centre rounds toward plus.
		write_reg(REG_GRID_COLS, 1);
		write_reg(REG_WEIGHT_X, 32'h0);
		write_reg(REG_WEIGHT_Y, 32'h0);
		write_reg(REG_CENTER_WEIGHT, 32'h2000_0000);
		run_grid(1, 1, PAT_TIE);

		// Phase one: hold the receiver off long enough to back up the input first.
		hold_req <= ~hold_req;
		run_random_phase(SMALL_SAMPLES);

		// Phase two: swap the idling rates; include a wide grid with a row count of zero.
		src_idle_pct  <= 46;
		sink_idle_pct <= 18;
		run_random_phase(SMALL_SAMPLES);
		write_reg(REG_GRID_COLS, 60);
		write_reg(REG_GRID_ROWS, 0);
		write_weights(WT_DIFFUSE);
		run_grid(60, 0, PAT_WIDE);

		// Phase three: no idling; a tall grid with a column count of zero, then small grids.
		src_idle_pct  <= 0;
		sink_idle_pct <= 0;
		write_reg(REG_GRID_COLS, 0);
		write_reg(REG_GRID_ROWS, 60);
		write_weights(WT_WIDE);
		run_grid(0, 60, PAT_CORNER);
		run_random_phase(SMALL_SAMPLES);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/h2d_pkg.sv
design/h2d_ram.sv
design/h2d_mac.sv
design/heat2d_explicit_stencil_step.sv
tb/sv/heat2d_stencil_checker.sv
tb/sv/tb_heat2d_explicit_stencil_step.sv
